>>> rtl/core/lsz_pkg.sv
// ----------------------------------------------------------------------------
// lsz_pkg
// Shared types and constants of the lidar safety zone stop block.
// ----------------------------------------------------------------------------
package lsz_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_SCAN    = 2'd0,
        OP_FORWARD = 2'd1,
        OP_BACK    = 2'd2,
        OP_STOP    = 2'd3
    } op_t;

    // Danger side codes
    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_AHEAD = 2'd1,
        SIDE_REAR  = 2'd2
    } side_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CHECK_ENABLE = 3'd0,
        CFG_LINK_PRESENT = 3'd1,
        CFG_BOX_LEFT     = 3'd2,
        CFG_BOX_TOP      = 3'd3,
        CFG_BOX_WIDTH    = 3'd4,
        CFG_BOX_HEIGHT   = 3'd5
    } cfg_sel_t;

    localparam int CFG_INDEX_BITS = 3;
    localparam int BOX_BITS       = 15;
    localparam int HEADING_BITS   = 8;

    localparam logic signed [HEADING_BITS-1:0] HEADING_MAX = 8'sh7F;
    localparam logic signed [HEADING_BITS-1:0] HEADING_MIN = 8'sh80;

    // Vehicle outline and margins, mm
    localparam int CAR_LENGTH      = 1300;
    localparam int CAR_WIDTH       = 750;
    localparam int CAR_REAR_OFFSET = 150;
    localparam int MARGIN_W        = 400;
    localparam int MARGIN_H        = 30;

    localparam logic signed [BOX_BITS-1:0] BOX_LEFT_RST =
        BOX_BITS'(-(CAR_REAR_OFFSET + MARGIN_W));
    localparam logic signed [BOX_BITS-1:0] BOX_TOP_RST =
        BOX_BITS'(-((CAR_WIDTH + 2 * MARGIN_H) / 2));
    localparam logic [BOX_BITS-1:0] BOX_WIDTH_RST  = BOX_BITS'(CAR_LENGTH + 2 * MARGIN_W);
    localparam logic [BOX_BITS-1:0] BOX_HEIGHT_RST = BOX_BITS'(CAR_WIDTH + 2 * MARGIN_H);

    // Quarter-wave sine polynomial, Q30 coefficients
    typedef logic [30:0] q30_t;
    localparam int   POLY_TERMS = 4;
    localparam q30_t COEF_A9    = 31'd172272;
    localparam q30_t POLY_COEF [POLY_TERMS] = '{
        31'd5026995,     // A7
        31'd85569306,    // A5
        31'd693598669,   // A3
        31'd1686629713   // A1
    };

    // Sine lane register stages: square, four polynomial steps, final product, rounding
    localparam int LANE_LAT = POLY_TERMS + 3;

    localparam int QUEUE_DEPTH    = 16;
    localparam int QUEUE_PTR_BITS = 4;

    typedef struct packed {
        logic check_enable;
        logic link_present;
    } mode_t;

    typedef struct packed {
        logic signed [BOX_BITS-1:0] left;
        logic signed [BOX_BITS-1:0] top;
        logic        [BOX_BITS-1:0] width;
        logic        [BOX_BITS-1:0] height;
    } box_cfg_t;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        op_t  op;
        logic bad;
        logic last;
        logic in_box;
        logic ahead;
        logic behind;
    } cls_item_t;

endpackage

>>> rtl/core/lsz_sine_lane.sv
// ----------------------------------------------------------------------------
// lsz_sine_lane
// Pipelined quarter-wave sine: at most one multiplier per stage, Q30 arithmetic,
// result rounded to FRAC_BITS and capped at 1.0.
// ----------------------------------------------------------------------------
module lsz_sine_lane #(
    parameter int FRAC_BITS = 15
) (
    input  logic                clk,
    input  lsz_pkg::q30_t       u,
    output logic [FRAC_BITS:0]  mag
);
    import lsz_pkg::*;

    localparam logic [32:0] ROUND = 33'd1 << (29 - FRAC_BITS);
    localparam logic [32:0] ONE   = 33'd1 << FRAC_BITS;

    logic [61:0] sq;
    q30_t        t2_next;
    q30_t        t2_reg;
    q30_t        u0_reg;

    q30_t        p_src   [POLY_TERMS];
    q30_t        t2_src  [POLY_TERMS];
    q30_t        u_src   [POLY_TERMS];
    logic [61:0] prod    [POLY_TERMS];
    q30_t        p_next  [POLY_TERMS];
    q30_t        p_reg   [POLY_TERMS];
    q30_t        t2_pipe_reg [POLY_TERMS-1];
    q30_t        u_pipe_reg  [POLY_TERMS];

    logic [61:0] r_prod;
    logic [31:0] r_next;
    logic [31:0] r_reg;
    logic [32:0] rnd;
    logic [32:0] scaled;
    logic [FRAC_BITS:0] mag_next;
    logic [FRAC_BITS:0] mag_reg;

    assign sq      = 62'(u) * 62'(u);
    assign t2_next = sq[60:30];

    always_comb
    begin
        p_src[0]  = COEF_A9;
        t2_src[0] = t2_reg;
        u_src[0]  = u0_reg;
        for (int i = 1; i < POLY_TERMS; i++)
        begin
            p_src[i]  = p_reg[i-1];
            t2_src[i] = t2_pipe_reg[i-1];
            u_src[i]  = u_pipe_reg[i-1];
        end
        for (int i = 0; i < POLY_TERMS; i++)
        begin
            prod[i]   = 62'(p_src[i]) * 62'(t2_src[i]);
            p_next[i] = POLY_COEF[i] - prod[i][60:30];
        end
    end

    assign r_prod   = 62'(p_reg[POLY_TERMS-1]) * 62'(u_pipe_reg[POLY_TERMS-1]);
    assign r_next   = r_prod[61:30];
    assign rnd      = {1'b0, r_reg} + ROUND;
    assign scaled   = rnd >> (30 - FRAC_BITS);
    assign mag_next = (scaled > ONE) ? ONE[FRAC_BITS:0] : scaled[FRAC_BITS:0];

    always_ff @(posedge clk)
    begin
        t2_reg <= t2_next;
        u0_reg <= u;
        for (int i = 0; i < POLY_TERMS; i++)
        begin
            p_reg[i]      <= p_next[i];
            u_pipe_reg[i] <= u_src[i];
        end
        for (int i = 0; i < POLY_TERMS - 1; i++)
        begin
            t2_pipe_reg[i] <= t2_src[i];
        end
        r_reg   <= r_next;
        mag_reg <= mag_next;
    end

    assign mag = mag_reg;

endmodule

>>> rtl/core/lsz_front.sv
// ----------------------------------------------------------------------------
// lsz_front
// Front end: registers accepted transactions, computes x and y of scan
// points and classifies them against the safety rectangle.
// ----------------------------------------------------------------------------
module lsz_front #(
    parameter int ANGLE_BITS         = 16,
    parameter int RANGE_BITS         = 14,
    parameter int TRIG_FRACTION_BITS = 15
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [1:0]             op,
    input  logic [ANGLE_BITS-1:0]  angle,
    input  logic [RANGE_BITS-1:0]  distance,
    input  logic                   bad_reading,
    input  logic                   last_point,
    input  lsz_pkg::box_cfg_t      box,
    output logic                   push,
    output lsz_pkg::cls_item_t     push_item
);
    import lsz_pkg::*;

    localparam int FRAC_W    = ANGLE_BITS - 2;
    localparam int PROD_BITS = RANGE_BITS + TRIG_FRACTION_BITS + 1;
    localparam int CMP_BITS  = (RANGE_BITS + 2 > BOX_BITS + 3) ? RANGE_BITS + 2
                                                                : BOX_BITS + 3;

    typedef struct packed {
        op_t                   op;
        logic [1:0]            quad;
        logic [RANGE_BITS-1:0] range_mm;
        logic                  bad;
        logic                  last;
    } side_info_t;

    // Input stage
    logic              s0_valid_reg;
    side_info_t        s0_side_reg;
    logic [FRAC_W-1:0] frac_reg;
    q30_t              u_a;
    q30_t              u_b;

    // Sideband alongside the sine lanes
    logic [LANE_LAT-1:0] lane_valid_reg;
    side_info_t          lane_side_reg [LANE_LAT];

    logic [TRIG_FRACTION_BITS:0] sin_a;
    logic [TRIG_FRACTION_BITS:0] sin_b;

    // Projection stage
    side_info_t                  lane_out;
    logic [TRIG_FRACTION_BITS:0] mag_c;
    logic [TRIG_FRACTION_BITS:0] mag_s;
    logic [PROD_BITS-1:0]        x_prod;
    logic [PROD_BITS-1:0]        y_prod;
    logic                        proj_valid_reg;
    side_info_t                  proj_side_reg;
    logic [RANGE_BITS-1:0]       xmag_reg;
    logic [RANGE_BITS-1:0]       ymag_reg;
    logic                        xneg_reg;
    logic                        yneg_reg;

    // Compare stage
    logic signed [CMP_BITS-1:0] x_val;
    logic signed [CMP_BITS-1:0] y_val;
    logic signed [CMP_BITS-1:0] left_reg;
    logic signed [CMP_BITS-1:0] right_reg;
    logic signed [CMP_BITS-1:0] top_reg;
    logic signed [CMP_BITS-1:0] bottom_reg;
    logic signed [CMP_BITS-1:0] centre_reg;
    logic signed [CMP_BITS-1:0] left_next;
    logic signed [CMP_BITS-1:0] top_next;
    logic signed [CMP_BITS-1:0] width_ext;
    logic signed [CMP_BITS-1:0] height_ext;
    logic signed [CMP_BITS-1:0] half_ext;
    logic                       push_reg;
    cls_item_t                  item_next;
    cls_item_t                  item_reg;

    // Hold control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            lane_valid_reg <= '0;
            proj_valid_reg <= 1'b0;
            push_reg       <= 1'b0;
        end
        else
        begin
            s0_valid_reg   <= accept;
            lane_valid_reg <= {lane_valid_reg[LANE_LAT-2:0], s0_valid_reg};
            proj_valid_reg <= lane_valid_reg[LANE_LAT-1];
            push_reg       <= proj_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_side_reg.op       <= op_t'(op);
            s0_side_reg.quad     <= angle[ANGLE_BITS-1 -: 2];
            s0_side_reg.range_mm <= distance;
            s0_side_reg.bad      <= bad_reading;
            s0_side_reg.last     <= last_point;
            frac_reg             <= angle[FRAC_W-1:0];
        end
    end

    assign u_a = 31'(frac_reg) << (32 - ANGLE_BITS);
    assign u_b = (31'd1 << 30) - u_a;

    lsz_sine_lane #(
        .FRAC_BITS (TRIG_FRACTION_BITS)
    ) u_lane_a (
        .clk (clk),
        .u   (u_a),
        .mag (sin_a)
    );

    lsz_sine_lane #(
        .FRAC_BITS (TRIG_FRACTION_BITS)
    ) u_lane_b (
        .clk (clk),
        .u   (u_b),
        .mag (sin_b)
    );

    always_ff @(posedge clk)
    begin
        lane_side_reg[0] <= s0_side_reg;
        for (int i = 1; i < LANE_LAT; i++)
        begin
            lane_side_reg[i] <= lane_side_reg[i-1];
        end
    end

    // Map quadrants by symmetry and project
    assign lane_out = lane_side_reg[LANE_LAT-1];
    assign mag_c    = lane_out.quad[0] ? sin_a : sin_b;
    assign mag_s    = lane_out.quad[0] ? sin_b : sin_a;
    assign x_prod   = PROD_BITS'(lane_out.range_mm) * PROD_BITS'(mag_c);
    assign y_prod   = PROD_BITS'(lane_out.range_mm) * PROD_BITS'(mag_s);

    always_ff @(posedge clk)
    begin
        proj_side_reg <= lane_out;
        xmag_reg      <= x_prod[TRIG_FRACTION_BITS +: RANGE_BITS];
        ymag_reg      <= y_prod[TRIG_FRACTION_BITS +: RANGE_BITS];
        xneg_reg      <= lane_out.quad[0] ^ lane_out.quad[1];
        yneg_reg      <= lane_out.quad[1];
    end

    // Rectangle bounds follow the configuration every cycle
    assign left_next  = CMP_BITS'($signed(box.left));
    assign top_next   = CMP_BITS'($signed(box.top));
    assign width_ext  = $signed(CMP_BITS'(box.width));
    assign height_ext = $signed(CMP_BITS'(box.height));
    assign half_ext   = $signed(CMP_BITS'(box.width >> 1));

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        right_reg  <= left_next + width_ext;
        top_reg    <= top_next;
        bottom_reg <= top_next + height_ext;
        centre_reg <= left_next + half_ext;
    end

    assign x_val = xneg_reg ? -$signed(CMP_BITS'(xmag_reg)) : $signed(CMP_BITS'(xmag_reg));
    assign y_val = yneg_reg ? -$signed(CMP_BITS'(ymag_reg)) : $signed(CMP_BITS'(ymag_reg));

    always_comb
    begin
        item_next.op     = proj_side_reg.op;
        item_next.bad    = proj_side_reg.bad;
        item_next.last   = proj_side_reg.last;
        item_next.in_box = (x_val >= left_reg) && (x_val < right_reg) &&
                           (y_val >= top_reg) && (y_val < bottom_reg);
        item_next.ahead  = x_val > centre_reg;
        item_next.behind = x_val < centre_reg;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign push      = push_reg;
    assign push_item = item_reg;

endmodule

>>> rtl/core/lsz_queue.sv
// ----------------------------------------------------------------------------
// lsz_queue
// Queue of classified items between front and back end, with a credit count
// that covers the items still in flight in the front end.
// ----------------------------------------------------------------------------
module lsz_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               reserve,
    output logic               can_reserve,
    input  logic               push,
    input  lsz_pkg::cls_item_t push_item,
    input  logic               pop,
    output logic               head_valid,
    output lsz_pkg::cls_item_t head_item
);
    import lsz_pkg::*;

    localparam logic [QUEUE_PTR_BITS:0] CREDIT_MAX = (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);

    cls_item_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;
    logic [QUEUE_PTR_BITS:0]   count_next;
    logic [QUEUE_PTR_BITS:0]   credit_reg;
    logic [QUEUE_PTR_BITS:0]   credit_next;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
        case ({reserve, pop})
            2'b10:   credit_next = credit_reg + 1'b1;
            2'b01:   credit_next = credit_reg - 1'b1;
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg  <= count_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign can_reserve = credit_reg < CREDIT_MAX;
    assign head_valid  = count_reg != '0;
    assign head_item   = mem_reg[rd_ptr_reg];

endmodule

>>> rtl/core/lsz_back.sv
// ----------------------------------------------------------------------------
// lsz_back
// Back end: scan, trip and heading state; one result per item into an
// output register.
// ----------------------------------------------------------------------------
module lsz_back (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  lsz_pkg::mode_t                             mode,
    input  logic                                       head_valid,
    input  lsz_pkg::cls_item_t                         head_item,
    output logic                                       pop,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [1:0]                                 danger_side,
    output logic                                       stop_command,
    output logic signed [lsz_pkg::HEADING_BITS-1:0]    heading_now,
    output logic                                       scan_done
);
    import lsz_pkg::*;

    logic signed [HEADING_BITS-1:0] heading_reg;
    logic signed [HEADING_BITS-1:0] heading_next;
    side_t                          danger_reg;
    side_t                          danger_next;
    side_t                          side;
    logic                           tripped_reg;
    logic                           tripped_next;
    logic                           scan_open_reg;
    logic                           scan_open_next;
    logic                           stop;
    logic                           done;

    logic                           out_valid_reg;
    side_t                          out_side_reg;
    logic                           out_stop_reg;
    logic signed [HEADING_BITS-1:0] out_heading_reg;
    logic                           out_done_reg;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        heading_next   = heading_reg;
        danger_next    = danger_reg;
        tripped_next   = tripped_reg;
        scan_open_next = scan_open_reg;
        side           = SIDE_NONE;
        stop           = 1'b0;
        done           = 1'b0;
        if (pop)
        begin
            if (head_item.op == OP_SCAN)
            begin
                // Open a new scan: forget the last trip and, with the check on, the danger side
                if (!scan_open_reg)
                begin
                    tripped_next = 1'b0;
                    if (mode.check_enable)
                    begin
                        danger_next = SIDE_NONE;
                    end
                end
                scan_open_next = 1'b1;
                if (mode.check_enable && !tripped_next && !head_item.bad && head_item.in_box)
                begin
                    if (heading_reg > 0 && head_item.ahead)
                    begin
                        side = SIDE_AHEAD;
                    end
                    else if (heading_reg < 0 && head_item.behind)
                    begin
                        side = SIDE_REAR;
                    end
                    if (side != SIDE_NONE)
                    begin
                        danger_next  = side;
                        tripped_next = 1'b1;
                        if (mode.link_present)
                        begin
                            stop         = 1'b1;
                            heading_next = '0;
                        end
                    end
                end
                if (head_item.last)
                begin
                    scan_open_next = 1'b0;
                    done           = 1'b1;
                end
            end
            else if (mode.link_present)
            begin
                unique case (head_item.op)
                    OP_FORWARD:
                    begin
                        if (heading_reg != HEADING_MAX)
                        begin
                            heading_next = heading_reg + 8'sd1;
                        end
                    end
                    OP_BACK:
                    begin
                        if (heading_reg != HEADING_MIN)
                        begin
                            heading_next = heading_reg - 8'sd1;
                        end
                    end
                    OP_STOP:
                    begin
                        heading_next = '0;
                    end
                    default:
                    begin
                        heading_next = heading_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg   <= '0;
            danger_reg    <= SIDE_NONE;
            tripped_reg   <= 1'b0;
            scan_open_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            heading_reg   <= heading_next;
            danger_reg    <= danger_next;
            tripped_reg   <= tripped_next;
            scan_open_reg <= scan_open_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_side_reg    <= danger_next;
            out_stop_reg    <= stop;
            out_heading_reg <= heading_next;
            out_done_reg    <= done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign danger_side  = out_side_reg;
    assign stop_command = out_stop_reg;
    assign heading_now  = out_heading_reg;
    assign scan_done    = out_done_reg;

endmodule

>>> rtl/core/lidar_safety_zone_stop.sv
// ----------------------------------------------------------------------------
// lidar_safety_zone_stop
// Protective field check for a lidar point stream with emergency stop.
//
// Takes one transaction per clock: scan points (angle, distance, error flag,
// end-of-scan mark) and move events (forward, back, stop). Every accepted
// transaction produces exactly one result transaction, in order. A good scan
// point is turned into x and y (Q1.TRIG_FRACTION_BITS sine and cosine from a
// pipelined quarter-wave polynomial, truncated toward zero) and checked
// against the half-open safety rectangle; a hit in the half ahead of the
// heading sign sets the danger side, pulses stop_command when the link is
// present (clearing the heading) and masks the rest of the scan. Sustained
// rate is one transaction per cycle while the result side does not stall; a
// result passes through the input register, the seven-stage sine pipeline and
// the projection, compare, queue and output registers.
// in_ready drops only while sixteen transactions sit between acceptance and
// the back end, which happens when the result side stalls. Write the
// configuration registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
module lidar_safety_zone_stop #(
    parameter int ANGLE_BITS         = 16,
    parameter int RANGE_BITS         = 14,
    parameter int TRIG_FRACTION_BITS = 15
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    // Configuration write port
    input  logic                                    cfg_write,
    input  logic [lsz_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [lsz_pkg::BOX_BITS-1:0]            cfg_data,

    // Input channel
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [1:0]                              op,
    input  logic [ANGLE_BITS-1:0]                   angle,
    input  logic [RANGE_BITS-1:0]                   distance,
    input  logic                                    bad_reading,
    input  logic                                    last_point,

    // Result channel
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [1:0]                              danger_side,
    output logic                                    stop_command,
    output logic signed [lsz_pkg::HEADING_BITS-1:0] heading_now,
    output logic                                    scan_done
);
    import lsz_pkg::*;

    mode_t     mode_reg;
    box_cfg_t  box_reg;
    logic      accept;
    logic      can_reserve;
    logic      push;
    cls_item_t push_item;
    logic      pop;
    logic      head_valid;
    cls_item_t head_item;

    // Configuration registers; writes to unused indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg.check_enable <= 1'b1;
            mode_reg.link_present <= 1'b1;
            box_reg.left          <= BOX_LEFT_RST;
            box_reg.top           <= BOX_TOP_RST;
            box_reg.width         <= BOX_WIDTH_RST;
            box_reg.height        <= BOX_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel_t'(cfg_index))
                CFG_CHECK_ENABLE: mode_reg.check_enable <= cfg_data[0];
                CFG_LINK_PRESENT: mode_reg.link_present <= cfg_data[0];
                CFG_BOX_LEFT:     box_reg.left          <= cfg_data;
                CFG_BOX_TOP:      box_reg.top           <= cfg_data;
                CFG_BOX_WIDTH:    box_reg.width         <= cfg_data;
                CFG_BOX_HEIGHT:   box_reg.height        <= cfg_data;
                default:          mode_reg              <= mode_reg;
            endcase
        end
    end

    // Accept only while a queue slot is guaranteed for the transaction
    assign in_ready = can_reserve;
    assign accept   = in_valid && can_reserve;

    // Front end: coordinates and rectangle classification
    lsz_front #(
        .ANGLE_BITS         (ANGLE_BITS),
        .RANGE_BITS         (RANGE_BITS),
        .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op),
        .angle       (angle),
        .distance    (distance),
        .bad_reading (bad_reading),
        .last_point  (last_point),
        .box         (box_reg),
        .push        (push),
        .push_item   (push_item)
    );

    // Decouple the free-running front end from the stallable back end
    lsz_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .reserve     (accept),
        .can_reserve (can_reserve),
        .push        (push),
        .push_item   (push_item),
        .pop         (pop),
        .head_valid  (head_valid),
        .head_item   (head_item)
    );

    // Back end: scan and heading state, result register
    lsz_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .danger_side  (danger_side),
        .stop_command (stop_command),
        .heading_now  (heading_now),
        .scan_done    (scan_done)
    );

endmodule

>>> rtl/core/lsz_checker.sv
// ----------------------------------------------------------------------------
// lsz_checker
// Port-level checks of the lidar safety zone stop block, bound to the top.
// ----------------------------------------------------------------------------
module lsz_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic [1:0]                              danger_side,
    input  logic                                    stop_command,
    input  logic signed [lsz_pkg::HEADING_BITS-1:0] heading_now,
    input  logic                                    scan_done
);
    import lsz_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(danger_side) &&
        $stable(stop_command) && $stable(heading_now) && $stable(scan_done))
        else $error("result changed while stalled");

    // A stop marks a side and clears the heading
    a_stop_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stop_command |-> danger_side != SIDE_NONE && heading_now == 8'sd0)
        else $error("stop without danger side or with heading left set");

    // After a stop the heading is zero, so the next result cannot stop again
    a_no_double_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && stop_command |=> !(out_valid && stop_command))
        else $error("two stop results in a row");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid at reset release");

endmodule

bind lidar_safety_zone_stop lsz_checker u_lsz_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .danger_side  (danger_side),
    .stop_command (stop_command),
    .heading_now  (heading_now),
    .scan_done    (scan_done)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar safety zone stop block.
//
// A queue of pending transactions feeds a clocked driver; a clocked monitor
// compares every result transaction against a zone predictor that runs on
// each accepted input. The run walks through several register settings: reset
// values, link absent, check disabled in the middle of a scan, a box covering
// the whole range, an empty box and random boxes. Both channels idle at
// random, except in one long steady stretch that also drives the heading
// count into both saturation limits.
// ----------------------------------------------------------------------------
module tb_top;

    import lsz_pkg::*;

    localparam int ANG_W       = 16;
    localparam int DIST_W      = 14;
    localparam int TRIG_FRAC   = 15;
    localparam int QUIET_LIMIT = 2000;   // cycles with no transaction at all
    localparam int SETTLE      = 20;     // extra wait after the bench queues drain

    // Quarter-wave sine polynomial coefficients, Q30
    localparam longint unsigned K_A1 = 64'd1686629713;
    localparam longint unsigned K_A3 = 64'd693598669;
    localparam longint unsigned K_A5 = 64'd85569306;
    localparam longint unsigned K_A7 = 64'd5026995;
    localparam longint unsigned K_A9 = 64'd172272;

    typedef struct {
        op_t               op;
        logic [ANG_W-1:0]  angle;
        logic [DIST_W-1:0] distance;
        logic              bad;
        logic              last;
    } pt_item_t;

    typedef struct {
        int danger;
        int stop;
        int heading;
        int done;
    } zone_result_t;

    // ------------------------------------------------------------------
    // DUT signals; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_write   = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
    logic [BOX_BITS-1:0]       cfg_data    = '0;
    logic                      in_valid    = 1'b0;
    logic                      in_ready;
    logic [1:0]                op          = '0;
    logic [ANG_W-1:0]          angle       = '0;
    logic [DIST_W-1:0]         distance    = '0;
    logic                      bad_reading = 1'b0;
    logic                      last_point  = 1'b0;
    logic                      out_valid;
    logic                      out_ready   = 1'b0;
    logic [1:0]                danger_side;
    logic                      stop_command;
    logic signed [HEADING_BITS-1:0] heading_now;
    logic                      scan_done;

    lidar_safety_zone_stop #(
        .ANGLE_BITS         (ANG_W),
        .RANGE_BITS         (DIST_W),
        .TRIG_FRACTION_BITS (TRIG_FRAC)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .angle        (angle),
        .distance     (distance),
        .bad_reading  (bad_reading),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .danger_side  (danger_side),
        .stop_command (stop_command),
        .heading_now  (heading_now),
        .scan_done    (scan_done)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    pt_item_t     pending_items[$];
    zone_result_t expected_results[$];
    pt_item_t     cur_item;
    zone_result_t got_result;
    bit           steady       = 1'b0;  // no idling on either side when set
    int           errors       = 0;
    int           items_in     = 0;
    int           results_out  = 0;
    int           stops_seen   = 0;
    int           cfg_writes   = 0;
    int           quiet_cycles = 0;

    // Zone predictor copy of the block's registers and state
    bit    zp_check_en;
    bit    zp_link_on;
    int    zp_left;
    int    zp_top;
    int    zp_width;
    int    zp_height;
    int    zp_heading;
    side_t zp_danger;
    bit    zp_tripped;
    bit    zp_scan_open;

    // ------------------------------------------------------------------
    // Zone predictor
    // ------------------------------------------------------------------

    // sin(pi/2 * u) for u in Q30, result rounded to Q1.15 and capped at 1.0
    function automatic longint unsigned quarter_wave(longint unsigned u);
        longint unsigned t2;
        longint unsigned p;
        longint unsigned r;
        longint unsigned f;
        t2 = (u * u) >> 30;
        p  = K_A9;
        p  = K_A7 - ((p * t2) >> 30);
        p  = K_A5 - ((p * t2) >> 30);
        p  = K_A3 - ((p * t2) >> 30);
        p  = K_A1 - ((p * t2) >> 30);
        r  = (p * u) >> 30;
        f  = (r + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC);
        return (f > (64'd1 << TRIG_FRAC)) ? (64'd1 << TRIG_FRAC) : f;
    endfunction

    // Map the quadrant by symmetry onto the quarter wave
    function automatic void unit_vector(input logic [ANG_W-1:0] ang,
                                        output longint s, output longint c);
        longint unsigned u;
        longint          a;
        longint          b;
        u = longint'(ang[ANG_W-3:0]) << (32 - ANG_W);
        a = longint'(quarter_wave(u));
        b = longint'(quarter_wave((64'd1 << 30) - u));
        case (ang[ANG_W-1:ANG_W-2])
            2'd0:    begin s = a;  c = b;  end
            2'd1:    begin s = b;  c = -a; end
            2'd2:    begin s = -a; c = -b; end
            default: begin s = -b; c = a;  end
        endcase
    endfunction

    // Range times a signed trig value, truncated toward zero
    function automatic longint project_range(logic [DIST_W-1:0] d, longint tr);
        longint unsigned m;
        longint          mag;
        m   = (tr < 0) ? longint'(-tr) : longint'(tr);
        mag = longint'((longint'(d) * m) >> TRIG_FRAC);
        return (tr < 0) ? -mag : mag;
    endfunction

    function automatic zone_result_t predict_zone_result(pt_item_t it);
        zone_result_t r;
        longint       s;
        longint       c;
        longint       x;
        longint       y;
        longint       cx;
        side_t        hit;
        int           stop_now;
        stop_now = 0;
        r.done   = 0;
        if (it.op == OP_SCAN)
        begin
            // First point of a revolution re-arms the check
            if (!zp_scan_open)
            begin
                zp_tripped = 1'b0;
                if (zp_check_en)
                    zp_danger = SIDE_NONE;
            end
            zp_scan_open = 1'b1;
            if (zp_check_en && !zp_tripped && !it.bad)
            begin
                unit_vector(it.angle, s, c);
                x   = project_range(it.distance, c);
                y   = project_range(it.distance, s);
                cx  = longint'(zp_left) + longint'(zp_width / 2);
                hit = SIDE_NONE;
                if (x >= zp_left && x < longint'(zp_left) + zp_width &&
                    y >= zp_top && y < longint'(zp_top) + zp_height)
                begin
                    if (zp_heading > 0 && x > cx)
                        hit = SIDE_AHEAD;
                    if (zp_heading < 0 && x < cx)
                        hit = SIDE_REAR;
                end
                if (hit != SIDE_NONE)
                begin
                    zp_danger  = hit;
                    zp_tripped = 1'b1;
                    if (zp_link_on)
                    begin
                        stop_now   = 1;
                        zp_heading = 0;
                    end
                end
            end
            if (it.last)
            begin
                zp_scan_open = 1'b0;
                r.done       = 1;
            end
        end
        else if (zp_link_on)
        begin
            case (it.op)
                OP_FORWARD: if (zp_heading < 127)  zp_heading++;
                OP_BACK:    if (zp_heading > -128) zp_heading--;
                default:    zp_heading = 0;
            endcase
        end
        r.danger  = int'(zp_danger);
        r.stop    = stop_now;
        r.heading = zp_heading;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic pt_item_t pt(op_t code, logic [ANG_W-1:0] ang,
                                    logic [DIST_W-1:0] dist_mm, int bad, int last);
        pt_item_t it;
        it.op       = code;
        it.angle    = ang;
        it.distance = dist_mm;
        it.bad      = (bad != 0);
        it.last     = (last != 0);
        return it;
    endfunction

    // Random content; ranges are mostly near the vehicle so that hits happen
    function automatic pt_item_t rand_item(op_t code, int last);
        pt_item_t    it;
        int unsigned pick;
        pick        = $urandom_range(0, 99);
        it.op       = code;
        it.angle    = ANG_W'($urandom_range(0, 65535));
        if (pick < 70)
            it.distance = DIST_W'($urandom_range(0, 2600));
        else if (pick < 90)
            it.distance = DIST_W'($urandom_range(0, 16383));
        else
            it.distance = (pick < 95) ? '0 : '1;
        it.bad      = ($urandom_range(0, 9) == 0);
        it.last     = (last != 0);
        return it;
    endfunction

    // Mostly whole revolutions and move runs, with broken scans and noise
    task automatic queue_traffic(int unsigned n);
        int unsigned made;
        int unsigned len;
        int unsigned kind;
        int unsigned k;
        op_t         dir;
        made = 0;
        while (made < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                // One revolution; drop the end mark now and then
                len = $urandom_range(1, 10);
                for (k = 0; k < len; k++)
                    pending_items.push_back(rand_item(OP_SCAN,
                        ((k == len - 1) && ($urandom_range(0, 9) != 0)) ? 1 : 0));
                made += len;
            end
            else if (kind < 88)
            begin
                len = $urandom_range(1, 6);
                dir = $urandom_range(0, 1) ? OP_FORWARD : OP_BACK;
                for (k = 0; k < len; k++)
                    pending_items.push_back(rand_item(dir, $urandom_range(0, 1)));
                made += len;
            end
            else if (kind < 93)
            begin
                pending_items.push_back(rand_item(OP_STOP, $urandom_range(0, 1)));
                made++;
            end
            else
            begin
                pending_items.push_back(rand_item(op_t'($urandom_range(0, 3)),
                                                  $urandom_range(0, 1)));
                made++;
            end
        end
    endtask

    // Write one register and mirror it into the predictor
    task automatic write_reg(cfg_sel_t idx, logic [BOX_BITS-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_CHECK_ENABLE: zp_check_en = val[0];
            CFG_LINK_PRESENT: zp_link_on  = val[0];
            CFG_BOX_LEFT:     zp_left     = int'($signed(val));
            CFG_BOX_TOP:      zp_top      = int'($signed(val));
            CFG_BOX_WIDTH:    zp_width    = int'(val);
            default:          zp_height   = int'(val);
        endcase
        cfg_writes++;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_box(int left, int top, int width, int height);
        write_reg(CFG_BOX_LEFT,   BOX_BITS'(left));
        write_reg(CFG_BOX_TOP,    BOX_BITS'(top));
        write_reg(CFG_BOX_WIDTH,  BOX_BITS'(width));
        write_reg(CFG_BOX_HEIGHT, BOX_BITS'(height));
    endtask

    // Hold until every queued transaction has gone in and every result is back
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: predict on every accepted transaction, then present the next
    // pending one, or idle. in_valid holds with its payload until accepted.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_zone_result(cur_item));
                items_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 20))
                begin
                    cur_item    = pending_items.pop_front();
                    op          <= cur_item.op;
                    angle       <= cur_item.angle;
                    distance    <= cur_item.distance;
                    bad_reading <= cur_item.bad;
                    last_point  <= cur_item.last;
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transaction with the oldest prediction,
    // and stall the result side at random.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_out++;
                if (stop_command)
                    stops_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transaction with no prediction waiting", $time);
                    errors++;
                end
                else
                begin
                    got_result = expected_results.pop_front();
                    check_field("danger_side",  got_result.danger,  int'(danger_side));
                    check_field("stop_command", got_result.stop,    int'(stop_command));
                    check_field("heading_now",  got_result.heading, int'(heading_now));
                    check_field("scan_done",    got_result.done,    int'(scan_done));
                end
            end
            out_ready <= steady || ($urandom_range(0, 99) >= 20);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Predictor starts from the block's reset values
        zp_check_en  = 1'b1;
        zp_link_on   = 1'b1;
        zp_left      = -(CAR_REAR_OFFSET + MARGIN_W);
        zp_top       = -((CAR_WIDTH + 2 * MARGIN_H) / 2);
        zp_width     = CAR_LENGTH + 2 * MARGIN_W;
        zp_height    = CAR_WIDTH + 2 * MARGIN_H;
        zp_heading   = 0;
        zp_danger    = SIDE_NONE;
        zp_tripped   = 1'b0;
        zp_scan_open = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // Directed pass on reset values: box x in [-550, 1550), y in [-405, 405),
        // centre x 500
        pending_items.push_back(pt(OP_SCAN,    16'h0000, 14'd1000,  0, 0)); // heading zero
        pending_items.push_back(pt(OP_SCAN,    16'h4000, 14'd300,   0, 1)); // end of scan
        pending_items.push_back(pt(OP_FORWARD, 16'hFFFF, 14'h3FFF,  1, 1));
        pending_items.push_back(pt(OP_FORWARD, 16'h0000, 14'd0,     0, 0));
        pending_items.push_back(pt(OP_SCAN,    16'hFFFF, 14'h3FFF,  0, 0)); // far outside
        pending_items.push_back(pt(OP_SCAN,    16'h0000, 14'd1000,  1, 0)); // flagged, skipped
        pending_items.push_back(pt(OP_SCAN,    16'h0000, 14'd1000,  0, 0)); // trip ahead
        pending_items.push_back(pt(OP_SCAN,    16'h0000, 14'd1200,  0, 0)); // masked
        pending_items.push_back(pt(OP_SCAN,    16'h8000, 14'd0,     0, 1));
        pending_items.push_back(pt(OP_BACK,    16'h1234, 14'd77,    0, 0));
        pending_items.push_back(pt(OP_BACK,    16'h0000, 14'd0,     1, 0));
        pending_items.push_back(pt(OP_BACK,    16'h0000, 14'd0,     0, 1));
        pending_items.push_back(pt(OP_SCAN,    16'h8000, 14'd500,   0, 0)); // trip rear
        pending_items.push_back(pt(OP_SCAN,    16'h0000, 14'd0,     0, 1));
        pending_items.push_back(pt(OP_FORWARD, 16'h0000, 14'd0,     0, 0));
        pending_items.push_back(pt(OP_STOP,    16'hAAAA, 14'h2AAA,  1, 1)); // manual stop
        pending_items.push_back(pt(OP_FORWARD, 16'h5555, 14'h1555,  0, 0));
        pending_items.push_back(pt(OP_SCAN,    16'h2000, 14'd600,   0, 0)); // just past bottom edge
        pending_items.push_back(pt(OP_SCAN,    16'hE000, 14'd1400,  0, 0));
        pending_items.push_back(pt(OP_SCAN,    16'h0800, 14'd1500,  0, 0)); // trip near edge
        pending_items.push_back(pt(OP_SCAN,    16'hC000, 14'h3FFF,  1, 1));
        pending_items.push_back(pt(OP_BACK,    16'h0000, 14'd0,     0, 0));
        pending_items.push_back(pt(OP_BACK,    16'h0000, 14'd0,     0, 0));
        pending_items.push_back(pt(OP_SCAN,    16'h8000, 14'd550,   0, 1)); // on left edge
        pending_items.push_back(pt(OP_FORWARD, 16'h0000, 14'd0,     0, 0));
        pending_items.push_back(pt(OP_SCAN,    16'h0000, 14'd1550,  0, 1)); // right edge, out
        wait_drained();

        // Reset values written back explicitly, random traffic
        write_reg(CFG_CHECK_ENABLE, BOX_BITS'(1));
        write_reg(CFG_LINK_PRESENT, BOX_BITS'(1));
        write_box(-(CAR_REAR_OFFSET + MARGIN_W), -((CAR_WIDTH + 2 * MARGIN_H) / 2),
                  CAR_LENGTH + 2 * MARGIN_W, CAR_WIDTH + 2 * MARGIN_H);
        queue_traffic(60);
        wait_drained();

        // Long steady stretch: drive the heading into both limits
        steady = 1'b1;
        repeat (132) pending_items.push_back(rand_item(OP_FORWARD, $urandom_range(0, 1)));
        pending_items.push_back(rand_item(OP_STOP, 0));
        repeat (132) pending_items.push_back(rand_item(OP_BACK, $urandom_range(0, 1)));
        pending_items.push_back(pt(OP_SCAN, 16'h8000, 14'd500, 0, 1));
        queue_traffic(40);
        wait_drained();
        steady = 1'b0;

        // Link absent: trips mark the side only, moves are frozen
        write_reg(CFG_LINK_PRESENT, BOX_BITS'(0));
        queue_traffic(90);
        // Leave a scan open across the next register change
        repeat (3) pending_items.push_back(rand_item(OP_SCAN, 0));
        wait_drained();

        // Check disabled in the middle of a scan
        write_reg(CFG_LINK_PRESENT, BOX_BITS'(1));
        write_reg(CFG_CHECK_ENABLE, BOX_BITS'(0));
        repeat (3) pending_items.push_back(rand_item(OP_SCAN, 0));
        queue_traffic(50);
        repeat (2) pending_items.push_back(rand_item(OP_SCAN, 0));
        wait_drained();

        // Re-enable mid-scan, box covering the whole range
        write_reg(CFG_CHECK_ENABLE, BOX_BITS'(1));
        write_box(-16384, -16384, 32767, 32767);
        queue_traffic(60);
        wait_drained();

        // Empty box at the far corner: nothing can be inside
        write_box(16383, 16383, 0, 0);
        queue_traffic(50);
        wait_drained();

        // Random boxes around the vehicle
        repeat (3)
        begin
            write_box($urandom_range(0, 2400) - 2000, $urandom_range(0, 1600) - 1200,
                      $urandom_range(0, 3500), $urandom_range(0, 2500));
            queue_traffic(30);
            wait_drained();
        end

        errors += expected_results.size();
        $display("Run covered %0d input transactions, %0d results, %0d stop pulses,",
                 items_in, results_out, stops_seen);
        $display("and %0d register writes across reset, link, check and box settings.",
                 cfg_writes);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
